// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hdl/crfb_pkg.sv -----
// ---------------------------------------------------------------------------
// crfb_pkg
// Shared types and constants for the rectangle fill and bitmap blitter.
// ---------------------------------------------------------------------------
package crfb_pkg;

  localparam int ScreenWidthDef  = 240;
  localparam int ScreenHeightDef = 320;

  localparam int CmdW   = 3;
  localparam int CoordW = 12;
  localparam int SizeW  = 11;
  localparam int ColorW = 16;
  localparam int ByteW  = 8;

  typedef enum logic [CmdW-1:0] {
    CMD_FILL     = 3'd0,
    CMD_BM_BEGIN = 3'd1,
    CMD_BM_BYTE  = 3'd2,
    CMD_LN_BEGIN = 3'd3,
    CMD_LN_PIX   = 3'd4,
    CMD_READ     = 3'd5
  } cmd_t;

  // Work handed from the front part to the back part
  typedef enum logic [1:0] {
    OP_RECT = 2'd0,
    OP_BITS = 2'd1,
    OP_READ = 2'd2
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [CoordW:0]   x0;
    logic signed [CoordW:0]   y0;
    logic signed [CoordW+1:0] x1;
    logic signed [CoordW+1:0] y1;
    logic [3:0]               nbits;
    logic [ByteW-1:0]         bits;
    logic [ColorW-1:0]        fg;
    logic [ColorW-1:0]        bg;
  } job_t;

  typedef enum logic [1:0] {
    RUN_IDLE   = 2'd0,
    RUN_BITMAP = 2'd1,
    RUN_LINE   = 2'd2
  } run_t;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_WORK  = 2'd2,
    BK_READ  = 2'd3
  } bk_state_t;

endpackage

// ----- hdl/crfb_front.sv -----
// ---------------------------------------------------------------------------
// crfb_front
// Accepts command words, tracks bitmap and line runs, and turns each drawing
// or read word into a clipped rectangle, a run of up to eight pixels, or a read job.
// ---------------------------------------------------------------------------
module crfb_front #(
  parameter int SCREEN_WIDTH  = crfb_pkg::ScreenWidthDef,
  parameter int SCREEN_HEIGHT = crfb_pkg::ScreenHeightDef
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        enable,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [crfb_pkg::CmdW-1:0]   command,
  input  logic signed [crfb_pkg::CoordW-1:0] x_pos,
  input  logic signed [crfb_pkg::CoordW-1:0] y_pos,
  input  logic [crfb_pkg::SizeW-1:0]  width,
  input  logic [crfb_pkg::SizeW-1:0]  height,
  input  logic [crfb_pkg::ColorW-1:0] color,
  input  logic [crfb_pkg::ColorW-1:0] background_color,
  input  logic [crfb_pkg::ByteW-1:0]  bitmap_byte,
  output logic                        job_valid,
  input  logic                        job_ready,
  output crfb_pkg::job_t              job
);
  import crfb_pkg::*;
  `include "assert_macros.svh"

  localparam logic signed [CoordW+1:0] SW = (CoordW+2)'(SCREEN_WIDTH);
  localparam logic signed [CoordW+1:0] SH = (CoordW+2)'(SCREEN_HEIGHT);

  run_t                     run_mode;
  logic signed [CoordW-1:0] org_x;
  logic signed [CoordW-1:0] org_y;
  logic [SizeW-1:0]         run_w;
  logic [SizeW-1:0]         run_h;
  logic [ColorW-1:0]        fg_latch;
  logic [ColorW-1:0]        bg_latch;
  logic [SizeW-1:0]         row_idx;
  logic [SizeW-1:0]         col_idx;

  logic accept;
  logic [SizeW:0] remain;
  logic [3:0]     take;
  logic signed [CoordW+1:0] rx0, ry0, rx1, ry1;
  logic signed [CoordW+1:0] px, py;
  job_t job_next;
  logic emit;

  assign in_ready = !job_valid || job_ready;
  assign accept   = in_valid && in_ready;

  // Remaining columns in the current bitmap row, capped at one byte
  always_comb begin
    remain = {1'b0, run_w} - {1'b0, col_idx};
    take   = (remain > (SizeW+1)'(8)) ? 4'd8 : remain[3:0];
  end

  // Clip a fill rectangle to the screen and build the job for each command
  always_comb begin
    rx0 = (CoordW+2)'(x_pos);
    ry0 = (CoordW+2)'(y_pos);
    rx1 = rx0 + (CoordW+2)'(width);
    ry1 = ry0 + (CoordW+2)'(height);
    px  = (CoordW+2)'(org_x) + (CoordW+2)'(col_idx);
    py  = (CoordW+2)'(org_y) + (CoordW+2)'(row_idx);
    job_next = '0;
    emit = 1'b0;
    job_next.fg = color;
    job_next.bg = background_color;
    unique case (command)
      CMD_FILL: begin
        emit = enable;
        job_next.op = OP_RECT;
        job_next.x0 = (CoordW+1)'(rx0 < 0 ? '0 : rx0);
        job_next.y0 = (CoordW+1)'(ry0 < 0 ? '0 : ry0);
        job_next.x1 = rx1 > SW ? SW : rx1;
        job_next.y1 = ry1 > SH ? SH : ry1;
      end
      CMD_BM_BYTE: begin
        emit = enable && run_mode == RUN_BITMAP;
        job_next.op = OP_BITS;
        job_next.x0 = (CoordW+1)'(px);
        job_next.y0 = (CoordW+1)'(py);
        job_next.nbits = take;
        job_next.bits = bitmap_byte;
        job_next.fg = fg_latch;
        job_next.bg = bg_latch;
      end
      CMD_LN_PIX: begin
        emit = enable && run_mode == RUN_LINE;
        job_next.op = OP_BITS;
        job_next.x0 = (CoordW+1)'(px);
        job_next.y0 = (CoordW+1)'((CoordW+2)'(org_y));
        job_next.nbits = 4'd1;
        job_next.bits = 8'h80;
      end
      CMD_READ: begin
        emit = 1'b1;
        job_next.op = OP_READ;
        job_next.x0 = (CoordW+1)'(rx0);
        job_next.y0 = (CoordW+1)'(ry0);
      end
      default: emit = 1'b0;
    endcase
  end

  // Hold one job for the back part
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept) begin
      job_valid <= emit;
    end else if (job_ready) begin
      job_valid <= 1'b0;
    end
    if (accept) job <= job_next;
  end

  // Advance run state
  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode <= RUN_IDLE;
      org_x <= '0; org_y <= '0; run_w <= '0; run_h <= '0;
      fg_latch <= '0; bg_latch <= '0; row_idx <= '0; col_idx <= '0;
    end else if (accept && enable) begin
      unique case (command)
        CMD_BM_BEGIN: begin
          org_x <= x_pos; org_y <= y_pos; run_w <= width; run_h <= height;
          fg_latch <= color; bg_latch <= background_color;
          row_idx <= '0; col_idx <= '0;
          run_mode <= (width != '0 && height != '0) ? RUN_BITMAP : RUN_IDLE;
        end
        CMD_BM_BYTE: begin
          if (run_mode == RUN_BITMAP) begin
            if (remain <= (SizeW+1)'(8)) begin
              col_idx <= '0;
              row_idx <= row_idx + 1'b1;
              if ({1'b0, row_idx} + 1'b1 >= {1'b0, run_h}) run_mode <= RUN_IDLE;
            end else begin
              col_idx <= col_idx + SizeW'(8);
            end
          end
        end
        CMD_LN_BEGIN: begin
          org_x <= x_pos; org_y <= y_pos; run_w <= width; col_idx <= '0;
          run_mode <= (width != '0) ? RUN_LINE : RUN_IDLE;
        end
        CMD_LN_PIX: begin
          if (run_mode == RUN_LINE) begin
            col_idx <= col_idx + 1'b1;
            if ({1'b0, col_idx} + 1'b1 >= {1'b0, run_w}) run_mode <= RUN_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPL(a_bitmap_cols, run_mode == RUN_BITMAP, col_idx < run_w, "column past width")
  `ASSERT_IMPL(a_line_cols, run_mode == RUN_LINE, col_idx < run_w, "line past count")
  `ASSERT_IMPL(a_bits_take, job_valid && job.op == OP_BITS, job.nbits != 4'd0,
               "empty pixel group")
endmodule

// ----- hdl/crfb_back.sv -----
// ---------------------------------------------------------------------------
// crfb_back
// Owns the frame memory: clears it after reset, then writes one pixel per
// cycle for rectangles and pixel groups and answers pixel reads.
// ---------------------------------------------------------------------------
module crfb_back #(
  parameter int SCREEN_WIDTH  = crfb_pkg::ScreenWidthDef,
  parameter int SCREEN_HEIGHT = crfb_pkg::ScreenHeightDef
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  output logic                        job_ready,
  input  crfb_pkg::job_t              job,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [crfb_pkg::ColorW-1:0] pixel_color,
  output logic                        inside_screen
);
  import crfb_pkg::*;
  `include "assert_macros.svh"

  localparam int Depth = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(Depth + 1);
  localparam logic signed [CoordW+1:0] SW = (CoordW+2)'(SCREEN_WIDTH);
  localparam logic signed [CoordW+1:0] SH = (CoordW+2)'(SCREEN_HEIGHT);

  logic [ColorW-1:0] mem [Depth];

  bk_state_t state, state_next;
  job_t      cur;
  logic signed [CoordW+1:0] cx, cy;
  logic [AW-1:0] row_base;
  logic [AW-1:0] clr_addr;
  logic [3:0]    bit_n;
  logic          rd_in;

  logic          we;
  logic [AW-1:0] waddr;
  logic [ColorW-1:0] wdata;
  logic          last_px;
  logic          rect_empty;
  logic          pix_on;
  logic [AW-1:0] pix_addr;
  logic [ColorW-1:0] rdata;
  logic          rd_go;

  // Current pixel address and on-screen check
  always_comb begin
    pix_on     = cx >= 0 && cx < SW && cy >= 0 && cy < SH;
    pix_addr   = row_base + AW'(cx[CoordW:0]);
    rect_empty = cur.op == OP_RECT && (cur.x0 >= cur.x1 || cur.y0 >= cur.y1);
    if (cur.op == OP_RECT) begin
      last_px = (cx + 1'b1 >= cur.x1) && (cy + 1'b1 >= cur.y1);
    end else begin
      last_px = (bit_n + 1'b1 >= cur.nbits);
    end
  end

  // Read data is ready once bit_n[0] marks that the memory has answered
  assign rd_go = state == BK_READ && bit_n[0] && (!out_valid || out_ready);

  // Next state and memory write control
  always_comb begin
    state_next = state;
    we = 1'b0;
    waddr = pix_addr;
    wdata = (cur.op == OP_RECT || cur.bits[3'(7 - bit_n[2:0])]) ? cur.fg : cur.bg;
    unique case (state)
      BK_CLEAR: begin
        we = 1'b1;
        waddr = clr_addr;
        wdata = '0;
        if (clr_addr == AW'(Depth - 1)) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (job_valid) begin
          state_next = (job.op == OP_READ) ? BK_READ : BK_WORK;
        end
      end
      BK_WORK: begin
        we = pix_on && !rect_empty;
        if (last_px || rect_empty)
          state_next = BK_IDLE;
      end
      BK_READ: begin
        if (rd_go) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign job_ready = (state == BK_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= BK_CLEAR;
    else     state <= state_next;
  end

  // Step through the job's pixels
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == BK_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
    if (state == BK_IDLE && job_valid) begin
      cur   <= job;
      cx    <= (CoordW+2)'(job.x0);
      cy    <= (CoordW+2)'(job.y0);
      bit_n <= '0;
      rd_in <= (CoordW+2)'(job.x0) >= 0 && (CoordW+2)'(job.x0) < SW &&
               (CoordW+2)'(job.y0) >= 0 && (CoordW+2)'(job.y0) < SH;
      row_base <= AW'(job.y0[CoordW-1:0]) * AW'(SCREEN_WIDTH);
    end else if (state == BK_WORK) begin
      bit_n <= bit_n + 1'b1;
      if (cur.op == OP_RECT && cx + 1'b1 >= cur.x1) begin
        cx <= (CoordW+2)'(cur.x0);
        cy <= cy + 1'b1;
        row_base <= row_base + AW'(SCREEN_WIDTH);
      end else begin
        cx <= cx + 1'b1;
      end
    end else if (state == BK_READ) begin
      // Hold the read address while the memory answers
      bit_n <= 4'd1;
    end
  end

  // Frame memory with one write port and one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[pix_addr];
  end

  // Register the read result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (rd_go) begin
      pixel_color   <= rd_in ? rdata : '0;
      inside_screen <= rd_in;
    end
  end

  `ASSERT_IMPL(a_no_take_clear, state == BK_CLEAR, !job_ready, "job taken while clearing")
  `ASSERT_IMPL(a_we_on, state == BK_WORK && we, pix_on, "write off screen")
  `ASSERT_IMPL(a_read_off_zero, out_valid && !inside_screen, pixel_color == '0, "off-screen read not zero")
endmodule

// ----- hdl/clipped_rect_fill_and_bitmap_blitter.sv -----
// Flow: the front part holds one job while the back part works on the previous one,
// so a new word is taken before the last is through; further words then wait. A read
// answers once the back part is idle and the output is free. Fills and pixel groups
// are stepped through one pixel per cycle; an ignored word draws nothing.
// Reset: synchronous; run state clears and the frame memory is swept to black at one
// pixel a cycle; one word may be taken and held.
// ---------------------------------------------------------------------------
// clipped_rect_fill_and_bitmap_blitter
// Top level: front part classifies words, back part draws into memory and answers reads.
// ---------------------------------------------------------------------------
module clipped_rect_fill_and_bitmap_blitter #(
  parameter int SCREEN_WIDTH  = crfb_pkg::ScreenWidthDef,
  parameter int SCREEN_HEIGHT = crfb_pkg::ScreenHeightDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[2:0]
  input  logic [2:0]  s_axis_tuser,
  // x_pos[11:0], y_pos[23:12], width[34:24], height[45:35],
  // color[61:46], background_color[77:62], bitmap_byte[85:78], zero pad
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_color[15:0], inside_screen[16], zero pad
  output logic [23:0] m_axis_tdata
);
  import crfb_pkg::*;

  logic enable;
  logic job_valid, job_ready;
  job_t job;
  logic [ColorW-1:0] pixel_color;
  logic inside_screen;

  // Hold the drawing enable register
  always_ff @(posedge clk) begin
    if (rst) enable <= 1'b1;
    else if (cfg_we) enable <= cfg_wdata;
  end

  crfb_front #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
    .clk, .rst, .enable,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .command(s_axis_tuser), .x_pos(s_axis_tdata[11:0]),
    .y_pos(s_axis_tdata[23:12]), .width(s_axis_tdata[34:24]),
    .height(s_axis_tdata[45:35]), .color(s_axis_tdata[61:46]),
    .background_color(s_axis_tdata[77:62]), .bitmap_byte(s_axis_tdata[85:78]),
    .job_valid, .job_ready, .job
  );

  crfb_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
    .clk, .rst, .job_valid, .job_ready, .job,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .pixel_color, .inside_screen
  );

  assign m_axis_tdata = {7'd0, inside_screen, pixel_color};
endmodule
